// File: sv/solar_pressure_accel_macros.svh
// Assertion macros for the block's modules; the queue uses them.
`ifndef SOLAR_PRESSURE_ACCEL_MACROS_SVH
`define SOLAR_PRESSURE_ACCEL_MACROS_SVH

// The condition must never hold at a clock edge outside reset.
`define SPA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// When the cause holds, the effect must hold at the next clock edge.
`define SPA_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);

`endif

// File: sv/spa_pkg.sv
package spa_pkg;

  localparam int W         = 48;
  localparam int VW        = 49;
  localparam int SQ_STEPS  = 31;
  localparam int DIV_STEPS = 31;
  localparam int UNIT_LAT  = 6 + SQ_STEPS + 1 + DIV_STEPS + 1;
  localparam int BACK_LAT  = 8;
  // Queue depth must be a power of two so that the pointers wrap by themselves.
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);

  localparam logic [26:0] KQ44       = 27'd80396290;
  localparam logic [15:0] ONE_Q14    = 16'd16384;
  localparam logic [15:0] REFL_RESET = 16'd16384;
  localparam logic [31:0] ATM_RESET  = 32'd2684355;
  localparam logic [46:0] RAD_RESET  = 47'd1073741824;

  typedef enum logic [1:0] {
    REG_REFLECTIVITY  = 2'd0,
    REG_AREA_TO_MASS  = 2'd1,
    REG_SHADOW_RADIUS = 2'd2
  } reg_index_t;

  typedef logic [2:0][W-1:0]  vec48_t;
  typedef logic [2:0][VW-1:0] vec49_t;
  typedef logic [2:0][31:0]   unit_t;

  typedef struct packed {
    vec48_t sat;
    vec48_t sun;
  } raw_item_t;

  typedef struct packed {
    vec48_t      sat;
    vec48_t      sun;
    vec49_t      diff;
    logic [14:0] ci;
    logic [15:0] cr;
  } work_item_t;

  typedef struct packed {
    logic empty;
    logic almost_full;
  } queue_status_t;

  // Index of the highest seven-bit group holding a one.
  function automatic logic [2:0] top_group(input logic [48:0] v);
    logic [2:0] g;
    g = '0;
    for (int i = 0; i < 7; i++) begin
      if (|v[i*7 +: 7]) g = 3'(i);
    end
    return g;
  endfunction

  // Position of the highest one in a seven-bit group.
  function automatic logic [2:0] top_bit7(input logic [6:0] b);
    logic [2:0] p;
    p = '0;
    for (int i = 0; i < 7; i++) begin
      if (b[i]) p = 3'(i);
    end
    return p;
  endfunction

endpackage

// File: sv/spa_queue.sv
`include "solar_pressure_accel_macros.svh"

module spa_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  spa_pkg::work_item_t   wr_item,
  input  logic                  pop,
  output spa_pkg::work_item_t   rd_item,
  output spa_pkg::queue_status_t status
);

  spa_pkg::work_item_t mem [spa_pkg::QDEPTH];
  logic [spa_pkg::QAW-1:0] wp;
  logic [spa_pkg::QAW-1:0] rp;
  logic [spa_pkg::QCW-1:0] count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign rd_item            = mem[rp];
  assign status.empty       = (count == '0);
  assign status.almost_full = (count >= spa_pkg::QCW'(spa_pkg::QDEPTH - 1));

  `SPA_ASSERT_NEVER(a_no_overflow, push && !pop && count == spa_pkg::QCW'(spa_pkg::QDEPTH), "queue written while full")
  `SPA_ASSERT_NEVER(a_no_underflow, pop && count == '0, "queue read while empty")
  `SPA_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + 1'b1, "queue count did not rise")

endmodule

// File: sv/spa_unit.sv
module spa_unit (
  input  logic            clk,
  input  spa_pkg::vec49_t vec,
  output spa_pkg::unit_t  unit
);

  localparam int SQ = spa_pkg::SQ_STEPS;
  localparam int DV = spa_pkg::DIV_STEPS;

  // Magnitude, group search, normalisation and squares.
  logic [2:0][48:0] r0_mag, r1_mag, r2_mag;
  logic [2:0]       r0_sgn, r1_sgn, r2_sgn, r3_sgn, r4_sgn;
  logic [48:0]      r0_or;
  logic [2:0]       r1_grp;
  logic [6:0]       r1_bits;
  logic             r1_zero, r2_zero, r3_zero, r4_zero;
  logic [5:0]       r2_k;
  logic [2:0][29:0] r3_a, r4_a;
  logic [2:0][59:0] r4_sq;

  logic [2:0][48:0] mag_c;
  logic [2:0][29:0] a_c;
  logic [2:0]       grp_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec[i][48] ? (~vec[i] + 1'b1) : vec[i];
      if (r2_k > 6'd29) a_c[i] = 30'(r2_mag[i] >> (r2_k - 6'd29));
      else a_c[i] = 30'(r2_mag[i] << (6'd29 - r2_k));
    end
    grp_c = spa_pkg::top_group(r0_or);
  end

  always_ff @(posedge clk) begin
    r0_mag  <= mag_c;
    r0_sgn  <= {vec[2][48], vec[1][48], vec[0][48]};
    r0_or   <= mag_c[0] | mag_c[1] | mag_c[2];
    r1_mag  <= r0_mag;
    r1_sgn  <= r0_sgn;
    r1_grp  <= grp_c;
    r1_bits <= r0_or[{3'b0, grp_c} * 6'd7 +: 7];
    r1_zero <= (r0_or == '0);
    r2_mag  <= r1_mag;
    r2_sgn  <= r1_sgn;
    r2_zero <= r1_zero;
    r2_k    <= {3'b0, r1_grp} * 6'd7 + {3'b0, spa_pkg::top_bit7(r1_bits)};
    r3_a    <= a_c;
    r3_sgn  <= r2_sgn;
    r3_zero <= r2_zero;
    for (int i = 0; i < 3; i++) begin
      r4_sq[i] <= r3_a[i] * r3_a[i];
    end
    r4_a    <= r3_a;
    r4_sgn  <= r3_sgn;
    r4_zero <= r3_zero;
  end

  // Square root, two radicand bits per stage. Stage zero holds the sum of squares.
  logic [61:0]      sx    [SQ+1];
  logic [30:0]      sr    [SQ+1];
  logic [31:0]      srem  [SQ+1];
  logic [2:0][29:0] sa    [SQ+1];
  logic [2:0]       ssg   [SQ+1];
  logic             sz    [SQ+1];
  logic [61:0]      sx_next   [SQ];
  logic [30:0]      sr_next   [SQ];
  logic [31:0]      srem_next [SQ];

  always_comb begin
    for (int j = 0; j < SQ; j++) begin
      logic [33:0] rt;
      logic [33:0] tr;
      rt = {srem[j], sx[j][61:60]};
      tr = {1'b0, sr[j], 2'b01};
      sx_next[j] = {sx[j][59:0], 2'b00};
      if (rt >= tr) begin
        srem_next[j] = 32'(rt - tr);
        sr_next[j]   = {sr[j][29:0], 1'b1};
      end else begin
        srem_next[j] = rt[31:0];
        sr_next[j]   = {sr[j][29:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    sx[0]   <= 62'(r4_sq[0]) + 62'(r4_sq[1]) + 62'(r4_sq[2]);
    sr[0]   <= '0;
    srem[0] <= '0;
    sa[0]   <= r4_a;
    ssg[0]  <= r4_sgn;
    sz[0]   <= r4_zero;
    for (int j = 0; j < SQ; j++) begin
      sx[j+1]   <= sx_next[j];
      sr[j+1]   <= sr_next[j];
      srem[j+1] <= srem_next[j];
      sa[j+1]   <= sa[j];
      ssg[j+1]  <= ssg[j];
      sz[j+1]   <= sz[j];
    end
  end

  // Rounded division of each normalised component by the norm, one quotient bit per stage.
  logic [2:0][30:0] dr  [DV+1];
  logic [2:0][30:0] dl  [DV+1];
  logic [2:0][30:0] dq  [DV+1];
  logic [30:0]      dn  [DV+1];
  logic [2:0]       dsg [DV+1];
  logic             dz  [DV+1];
  logic [2:0][30:0] dr_next [DV];
  logic [2:0][30:0] dq_next [DV];
  logic [2:0][60:0] num_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = {1'b0, sa[SQ][i], 30'b0} + {31'b0, sr[SQ][30:1]};
    end
    for (int j = 0; j < DV; j++) begin
      for (int i = 0; i < 3; i++) begin
        logic [31:0] t;
        t = {dr[j][i], dl[j][i][30]};
        if (t >= {1'b0, dn[j]}) begin
          dr_next[j][i] = 31'(t - {1'b0, dn[j]});
          dq_next[j][i] = {dq[j][i][29:0], 1'b1};
        end else begin
          dr_next[j][i] = t[30:0];
          dq_next[j][i] = {dq[j][i][29:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dr[0][i] <= {1'b0, num_c[i][60:31]};
      dl[0][i] <= num_c[i][30:0];
      dq[0][i] <= '0;
    end
    dn[0]  <= sr[SQ];
    dsg[0] <= ssg[SQ];
    dz[0]  <= sz[SQ];
    for (int j = 0; j < DV; j++) begin
      dr[j+1] <= dr_next[j];
      dq[j+1] <= dq_next[j];
      for (int i = 0; i < 3; i++) begin
        dl[j+1][i] <= {dl[j][i][29:0], 1'b0};
      end
      dn[j+1]  <= dn[j];
      dsg[j+1] <= dsg[j];
      dz[j+1]  <= dz[j];
    end
    for (int i = 0; i < 3; i++) begin
      if (dz[DV]) unit[i] <= '0;
      else if (dsg[DV][i]) unit[i] <= ~{1'b0, dq[DV][i]} + 1'b1;
      else unit[i] <= {1'b0, dq[DV][i]};
    end
  end

endmodule

// File: sv/spa_front.sv
module spa_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  spa_pkg::raw_item_t     item,
  input  logic [15:0]            reflectivity,
  input  spa_pkg::queue_status_t q_status,
  output logic                   push,
  output spa_pkg::work_item_t    entry
);

  logic               f_valid;
  spa_pkg::raw_item_t f_item;

  assign busy = q_status.almost_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      f_item <= item;
    end
  end

  // Difference vector and split of the coefficient into incident and reflected parts.
  always_comb begin
    entry.sat = f_item.sat;
    entry.sun = f_item.sun;
    for (int i = 0; i < 3; i++) begin
      entry.diff[i] = {f_item.sat[i][47], f_item.sat[i]} - {f_item.sun[i][47], f_item.sun[i]};
    end
    if (reflectivity > spa_pkg::ONE_Q14) begin
      entry.cr = reflectivity - spa_pkg::ONE_Q14;
      entry.ci = spa_pkg::ONE_Q14[14:0];
    end else begin
      entry.cr = reflectivity;
      entry.ci = '0;
    end
  end

  assign push = f_valid;

endmodule

// File: sv/spa_back.sv
module spa_back (
  input  logic                   clk,
  input  logic                   rst,
  input  spa_pkg::queue_status_t q_status,
  input  spa_pkg::work_item_t    q_item,
  output logic                   pop,
  input  logic [46:0]            shadow_radius,
  input  logic [58:0]            ka,
  output spa_pkg::vec48_t        accel,
  output logic                   in_shadow,
  output logic                   done
);

  localparam int UL = spa_pkg::UNIT_LAT;

  logic                b0_valid;
  spa_pkg::work_item_t b0_item;
  spa_pkg::vec49_t     sun_v, sat_v;
  spa_pkg::unit_t      uu, us, uh;

  assign pop = !q_status.empty;

  always_ff @(posedge clk) begin
    if (rst) b0_valid <= 1'b0;
    else b0_valid <= pop;
  end

  always_ff @(posedge clk) begin
    if (pop) b0_item <= q_item;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sun_v[i] = {b0_item.sun[i][47], b0_item.sun[i]};
      sat_v[i] = {b0_item.sat[i][47], b0_item.sat[i]};
    end
  end

  spa_unit u_sun (.clk(clk), .vec(sun_v),        .unit(uu));
  spa_unit u_dif (.clk(clk), .vec(b0_item.diff), .unit(us));
  spa_unit u_sat (.clk(clk), .vec(sat_v),        .unit(uh));

  // Side data travels alongside the unit vector pipelines.
  logic            dv   [1:UL];
  spa_pkg::vec48_t dsat [1:UL];
  logic [14:0]     dci  [1:UL];
  logic [15:0]     dcr  [1:UL];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 1; j <= UL; j++) dv[j] <= 1'b0;
    end else begin
      dv[1] <= b0_valid;
      for (int j = 1; j < UL; j++) dv[j+1] <= dv[j];
    end
  end

  always_ff @(posedge clk) begin
    dsat[1] <= b0_item.sat;
    dci[1]  <= b0_item.ci;
    dcr[1]  <= b0_item.cr;
    for (int j = 1; j < UL; j++) begin
      dsat[j+1] <= dsat[j];
      dci[j+1]  <= dci[j];
      dcr[j+1]  <= dcr[j];
    end
  end

  logic c1_v, c2_v, c3_v, c4_v, c5_v, c6_v, c7_v;

  logic [2:0][47:0]  c1_smag, c2_smag;
  logic [2:0]        c1_ssg, c2_ssg;
  logic [2:0]        c1_grp;
  logic [6:0]        c1_bits;
  logic [4:0]        c2_g;
  spa_pkg::unit_t    c1_uu, c2_uu, c3_uu;
  logic signed [47:0] c1_pi [3];
  logic signed [48:0] c1_pr [3];
  logic [29:0]        c3_spm [3];
  logic signed [30:0] c3_sp  [3];
  logic [29:0]        c3_rr;
  logic [59:0]        c4_sq [3];
  logic signed [62:0] c4_dp [3];
  logic [59:0]        c4_rr2, c5_rr2, c6_rr2, c7_rr2;
  logic [61:0]        c5_ss, c6_ss, c7_ss;
  logic signed [64:0] c5_p;
  logic               c6_pneg, c7_pneg;
  logic [31:0]        c6_q;
  logic [63:0]        c7_q2;
  spa_pkg::vec48_t    accel_hold5, accel_hold6, accel_hold7;

  logic [2:0][47:0] smag_c;
  logic [48:0]      sor_c;
  logic [2:0]       grp_c;
  logic [5:0]       k_c;
  logic [63:0]      pm_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      smag_c[i] = dsat[UL][i][47] ? (~dsat[UL][i] + 1'b1) : dsat[UL][i];
    end
    sor_c = {1'b0, smag_c[0] | smag_c[1] | smag_c[2] | {1'b0, shadow_radius}};
    grp_c = spa_pkg::top_group(sor_c);
    k_c   = {3'b0, c1_grp} * 6'd7 + {3'b0, spa_pkg::top_bit7(c1_bits)};
    pm_c  = c5_p[64] ? 64'(-c5_p) : 64'(c5_p);
  end

  // Scaling and shadow stages; the three components share the same flow.
  always_ff @(posedge clk) begin
    if (rst) begin
      {c1_v, c2_v, c3_v, c4_v, c5_v, c6_v, c7_v, done} <= '0;
    end else begin
      {c1_v, c2_v, c3_v, c4_v, c5_v, c6_v, c7_v, done} <=
        {dv[UL], c1_v, c2_v, c3_v, c4_v, c5_v, c6_v, c7_v};
    end
  end

  logic [2:0]       c2_wneg_v, c3_wneg_v, c4_wneg_v;
  logic [2:0][47:0] c2_wmag_v;
  logic [2:0][63:0] c3_p00_v;
  logic [2:0][47:0] c3_p01_v;
  logic [2:0][58:0] c3_p10_v;
  logic [2:0][42:0] c3_p11_v;
  logic [2:0][106:0] c4_prod_v;
  logic [2:0][47:0] acc_c;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [107:0] rnd;
      logic [47:0]  mg;
      logic [47:0]  lim;
      rnd = {1'b0, c4_prod_v[i]} + (108'd1 << 59);
      mg  = rnd[107:60];
      lim = c4_wneg_v[i] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      if (mg > lim) mg = lim;
      acc_c[i] = c4_wneg_v[i] ? (~mg + 1'b1) : mg;
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1: magnitudes for the shadow test, coefficient products.
    c1_smag <= smag_c;
    c1_ssg  <= {dsat[UL][2][47], dsat[UL][1][47], dsat[UL][0][47]};
    c1_grp  <= grp_c;
    c1_bits <= sor_c[{3'b0, grp_c} * 6'd7 +: 7];
    c1_uu   <= uu;
    for (int i = 0; i < 3; i++) begin
      c1_pi[i] <= $signed({1'b0, dci[UL]}) * $signed(us[i]);
      c1_pr[i] <= $signed({1'b0, dcr[UL]}) * $signed(uh[i]);
    end
    // Stage 2: shadow shift count, combined vector.
    c2_smag <= c1_smag;
    c2_ssg  <= c1_ssg;
    c2_uu   <= c1_uu;
    c2_g    <= (k_c >= 6'd30) ? 5'(k_c - 6'd29) : 5'd0;
    for (int i = 0; i < 3; i++) begin
      logic signed [49:0] w;
      logic [49:0]        wm;
      w  = 50'(c1_pi[i]) - 50'(c1_pr[i]);
      wm = w[49] ? 50'(-w) : 50'(w);
      c2_wneg_v[i] <= w[49];
      c2_wmag_v[i] <= wm[47:0];
    end
    // Stage 3: scaled satellite position, partial products of the scaling.
    c3_uu <= c2_uu;
    for (int i = 0; i < 3; i++) begin
      logic [29:0] m;
      m = 30'(c2_smag[i] >> c2_g);
      c3_spm[i] <= m;
      c3_sp[i]  <= c2_ssg[i] ? -$signed({1'b0, m}) : $signed({1'b0, m});
      c3_p00_v[i] <= ka[31:0] * c2_wmag_v[i][31:0];
      c3_p01_v[i] <= ka[31:0] * c2_wmag_v[i][47:32];
      c3_p10_v[i] <= ka[58:32] * c2_wmag_v[i][31:0];
      c3_p11_v[i] <= ka[58:32] * c2_wmag_v[i][47:32];
    end
    c3_wneg_v <= c2_wneg_v;
    c3_rr     <= 30'({1'b0, shadow_radius} >> c2_g);
    // Stage 4: squares and dot product terms, full scaling product.
    for (int i = 0; i < 3; i++) begin
      c4_sq[i] <= c3_spm[i] * c3_spm[i];
      c4_dp[i] <= c3_sp[i] * $signed(c3_uu[i]);
      c4_prod_v[i] <= 107'(c3_p00_v[i]) + (107'(c3_p01_v[i]) << 32)
                    + (107'(c3_p10_v[i]) << 32) + (107'(c3_p11_v[i]) << 64);
    end
    c4_wneg_v <= c3_wneg_v;
    c4_rr2    <= c3_rr * c3_rr;
    // Stage 5: sums, rounded and saturated acceleration.
    c5_ss  <= 62'(c4_sq[0]) + 62'(c4_sq[1]) + 62'(c4_sq[2]);
    c5_p   <= 65'(c4_dp[0]) + 65'(c4_dp[1]) + 65'(c4_dp[2]);
    c5_rr2 <= c4_rr2;
    for (int i = 0; i < 3; i++) accel_hold5[i] <= acc_c[i];
    // Stage 6: rounded projection along the sun direction.
    c6_pneg <= c5_p[64];
    c6_q    <= 32'((pm_c + 64'd536870912) >> 30);
    c6_ss   <= c5_ss;
    c6_rr2  <= c5_rr2;
    accel_hold6 <= accel_hold5;
    // Stage 7: square of the projection.
    c7_q2   <= c6_q * c6_q;
    c7_pneg <= c6_pneg;
    c7_ss   <= c6_ss;
    c7_rr2  <= c6_rr2;
    accel_hold7 <= accel_hold6;
    // Stage 8: shadow decision and result register.
    in_shadow <= c7_pneg && ({3'b0, c7_ss} < ({1'b0, c7_q2} + {5'b0, c7_rr2}));
    if (c7_pneg && ({3'b0, c7_ss} < ({1'b0, c7_q2} + {5'b0, c7_rr2}))) accel <= '0;
    else accel <= accel_hold7;
  end

endmodule

// File: sv/solar_pressure_accel.sv
// Solar radiation pressure acceleration, spherical model with a cylindrical shadow.
//
// Input channel: an item (satellite and sun positions, signed Q17.30) is taken at a
// rising edge at which start is high and busy is low. A new word may be offered in
// every cycle; busy rises only if the small queue behind the input register fills.
// Output channel: done is high for exactly one cycle with accel_x/y/z and in_shadow.
// The receiver cannot hold results off, and the block never needs it to.
// Throughput is one word per clock while busy is low. A taken item passes through
// the input register, the queue, the read register and the unit vector pipelines,
// where the square root and the rounded division each resolve one result bit per
// stage (31 stages apiece), followed by eight stages of scaling and shadow test.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always
// high. Index 0 is the reflectivity (Q2.14), 1 the area to mass ratio (Q4.28) and
// 2 the shadow radius. The user writes only with no item in flight (not enforced).
// Reset (synchronous, active high) empties the queue and the pipeline and restores
// the register defaults: reflectivity one, area to mass about 0.01, radius one.
module solar_pressure_accel (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [47:0] sat_x,
  input  logic signed [47:0] sat_y,
  input  logic signed [47:0] sat_z,
  input  logic signed [47:0] sun_x,
  input  logic signed [47:0] sun_y,
  input  logic signed [47:0] sun_z,
  output logic               done,
  output logic signed [47:0] accel_x,
  output logic signed [47:0] accel_y,
  output logic signed [47:0] accel_z,
  output logic               in_shadow,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [46:0]        cfg_data
);

  logic [15:0] reflectivity;
  logic [31:0] area_to_mass;
  logic [46:0] shadow_radius;
  // Constant times area to mass, kept ready for the scaling multiplier.
  logic [58:0] ka;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      reflectivity  <= spa_pkg::REFL_RESET;
      area_to_mass  <= spa_pkg::ATM_RESET;
      shadow_radius <= spa_pkg::RAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (spa_pkg::reg_index_t'(cfg_index))
        spa_pkg::REG_REFLECTIVITY:  reflectivity  <= cfg_data[15:0];
        spa_pkg::REG_AREA_TO_MASS:  area_to_mass  <= cfg_data[31:0];
        spa_pkg::REG_SHADOW_RADIUS: shadow_radius <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    ka <= 59'(spa_pkg::KQ44) * 59'(area_to_mass);
  end

  spa_pkg::raw_item_t     item;
  spa_pkg::queue_status_t q_status;
  spa_pkg::work_item_t    push_item;
  spa_pkg::work_item_t    head_item;
  spa_pkg::vec48_t        accel;
  logic                   push;
  logic                   pop;

  assign item.sat = {sat_z, sat_y, sat_x};
  assign item.sun = {sun_z, sun_y, sun_x};

  spa_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .item         (item),
    .reflectivity (reflectivity),
    .q_status     (q_status),
    .push         (push),
    .entry        (push_item)
  );

  spa_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_item (push_item),
    .pop     (pop),
    .rd_item (head_item),
    .status  (q_status)
  );

  spa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_status      (q_status),
    .q_item        (head_item),
    .pop           (pop),
    .shadow_radius (shadow_radius),
    .ka            (ka),
    .accel         (accel),
    .in_shadow     (in_shadow),
    .done          (done)
  );

  assign accel_x = accel[0];
  assign accel_y = accel[1];
  assign accel_z = accel[2];

endmodule

// File: tb/solar_pressure_accel_tb.sv
`timescale 1ns / 100ps

module solar_pressure_accel_tb;
  import spa_pkg::*;

  // Limit on the whole run in clock cycles. The slowest correct run is about
  // 1150 words with random gaps between bursts, a drain around each register
  // phase and the pipeline latency at the end. The limit is about ten times
  // the length of that run.
  localparam int CYCLE_LIMIT = 200000;
  // Latency of the block, from the accepting edge to the result strobe, with margin.
  localparam int SETTLE      = 120;

  typedef longint trio_t [3];

  typedef struct {
    logic [47:0] ax;
    logic [47:0] ay;
    logic [47:0] az;
    logic        shadow;
  } accel_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [47:0] sat_x, sat_y, sat_z;
  logic signed [47:0] sun_x, sun_y, sun_z;
  logic               done;
  logic signed [47:0] accel_x, accel_y, accel_z;
  logic               in_shadow;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [46:0]        cfg_data;

  solar_pressure_accel u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .sat_x     (sat_x),
    .sat_y     (sat_y),
    .sat_z     (sat_z),
    .sun_x     (sun_x),
    .sun_y     (sun_y),
    .sun_z     (sun_z),
    .done      (done),
    .accel_x   (accel_x),
    .accel_y   (accel_y),
    .accel_z   (accel_z),
    .in_shadow (in_shadow),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the configuration registers, kept in step with every write.
  longint unsigned refl_reg;
  longint unsigned atm_reg;
  longint unsigned radius_reg;

  accel_t accel_q[$];
  int     mismatches;
  int     results_seen;
  int     shadow_seen;
  int     words_sent;
  int     burst_left;
  int     cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction of the block in fixed point.
  // ---------------------------------------------------------------------------

  function automatic longint unsigned mag(input longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // Floor of the square root, one result bit per pass.
  function automatic longint unsigned floor_sqrt(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Direction of a vector in Q1.30. The components are first normalised so that
  // the largest lies in [2^29, 2^30), which keeps the sum of squares in 64 bits.
  function automatic void unit_dir(input trio_t v, output trio_t u);
    longint unsigned m, sum, n, q;
    longint unsigned a [3];
    int r, l;
    m = 0;
    sum = 0;
    r = 0;
    l = 0;
    for (int i = 0; i < 3; i++) if (mag(v[i]) > m) m = mag(v[i]);
    if (m == 0) begin
      u = '{0, 0, 0};
      return;
    end
    while ((m >> r) >= (64'd1 << 30)) r++;
    while (((m >> r) << l) < (64'd1 << 29)) l++;
    for (int i = 0; i < 3; i++) begin
      a[i] = (mag(v[i]) >> r) << l;
      sum += a[i] * a[i];
    end
    n = floor_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 30) + (n >> 1)) / n;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  // Cylindrical shadow behind the Earth: the satellite must lie on the anti-sun
  // side and within the radius of the sun line.
  function automatic logic in_cylinder(input trio_t s, input trio_t sun_dir);
    longint unsigned m, ss, rr, pm, q;
    longint sp, p;
    int g;
    m = radius_reg;
    ss = 0;
    p = 0;
    g = 0;
    for (int i = 0; i < 3; i++) if (mag(s[i]) > m) m = mag(s[i]);
    while ((m >> g) >= (64'd1 << 30)) g++;
    for (int i = 0; i < 3; i++) begin
      sp = s[i] < 0 ? -longint'(mag(s[i]) >> g) : longint'(mag(s[i]) >> g);
      ss += mag(sp) * mag(sp);
      p += sp * sun_dir[i];
    end
    rr = radius_reg >> g;
    if (p >= 0) return 1'b0;
    pm = mag(p);
    q = (pm + (64'd1 << 29)) >> 30;
    return ss < q * q + rr * rr;
  endfunction

  // Rounded product of the scale factor and one axis of the Q.44 direction sum,
  // saturated to 48 bits.
  function automatic logic [47:0] scale_axis(input longint w, input longint unsigned ka);
    logic [127:0]    t;
    longint unsigned mg, lim;
    t = {64'd0, ka} * {64'd0, mag(w)} + (128'd1 << 59);
    if (|t[127:107]) mg = 64'h8000_0000_0000;
    else mg = t[123:60];
    lim = w < 0 ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
    if (mg > lim) mg = lim;
    return w < 0 ? 48'(longint'(0) - longint'(mg)) : 48'(mg);
  endfunction

  function automatic accel_t predict_accel(input logic signed [47:0] s_in [3],
                                           input logic signed [47:0] u_in [3]);
    trio_t s, u, d, sun_dir, beam_dir, radial_dir;
    longint w [3];
    longint cr, ci;
    longint unsigned ka;
    accel_t e;
    for (int i = 0; i < 3; i++) begin
      s[i] = s_in[i];
      u[i] = u_in[i];
      d[i] = s[i] - u[i];
    end
    unit_dir(u, sun_dir);
    if (in_cylinder(s, sun_dir)) begin
      e = '{48'd0, 48'd0, 48'd0, 1'b1};
      return e;
    end
    unit_dir(d, beam_dir);
    unit_dir(s, radial_dir);
    // Above one, the excess reflects and the rest is absorbed as incident push.
    if (refl_reg > 64'(ONE_Q14)) begin
      cr = refl_reg - 64'(ONE_Q14);
      ci = 64'(ONE_Q14);
    end else begin
      cr = refl_reg;
      ci = 0;
    end
    ka = 64'(KQ44) * atm_reg;
    for (int i = 0; i < 3; i++) w[i] = ci * beam_dir[i] - cr * radial_dir[i];
    e.ax = scale_axis(w[0], ka);
    e.ay = scale_axis(w[1], ka);
    e.az = scale_axis(w[2], ka);
    e.shadow = 1'b0;
    return e;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving the input and configuration channels.
  // ---------------------------------------------------------------------------

  // Offers one word; returns at the edge that accepts it or, if it ends a burst,
  // after the random gap in which start drops. Start stays high across a burst, so
  // back-to-back words are offered in consecutive cycles.
  task automatic send_word(input logic signed [47:0] s [3], input logic signed [47:0] u [3]);
    logic signed [47:0] s_c [3];
    logic signed [47:0] u_c [3];
    s_c = s;
    u_c = u;
    start <= 1'b1;
    sat_x <= s[0];
    sat_y <= s[1];
    sat_z <= s[2];
    sun_x <= u[0];
    sun_y <= u[1];
    sun_z <= u[2];
    do @(posedge clk); while (busy);
    accel_q.push_back(predict_accel(s_c, u_c));
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      // Now and then a long stretch with no gaps at all.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(0, 12);
    end
  endtask

  // Lowers start and waits until every expected result has come back.
  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (accel_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input longint unsigned value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 47'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_REFLECTIVITY:  refl_reg   = value & 64'hFFFF;
      REG_AREA_TO_MASS:  atm_reg    = value & 64'hFFFF_FFFF;
      REG_SHADOW_RADIUS: radius_reg = value & 64'h7FFF_FFFF_FFFF;
      default: ;
    endcase
  endtask

  task automatic set_regs(input longint unsigned refl, input longint unsigned atm,
                          input longint unsigned radius);
    write_reg(REG_REFLECTIVITY, refl);
    write_reg(REG_AREA_TO_MASS, atm);
    write_reg(REG_SHADOW_RADIUS, radius);
  endtask

  // ---------------------------------------------------------------------------
  // Random geometry.
  // ---------------------------------------------------------------------------

  function automatic logic signed [47:0] any48();
    return 48'({$urandom, $urandom});
  endfunction

  // A signed value whose magnitude has a random number of bits, so that the
  // normalisation shifts of the direction units are all exercised.
  function automatic logic signed [47:0] spread48();
    logic [47:0] v;
    v = 48'({$urandom, $urandom}) >> $urandom_range(0, 47);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // One geometric case: a distant sun and a satellite near the Earth, often placed
  // behind the Earth so that the shadow boundary is reached from both sides.
  task automatic random_geometry(output logic signed [47:0] s [3],
                                 output logic signed [47:0] u [3]);
    int ax;
    longint sun_dist, along, perp_lim;
    ax = $urandom_range(0, 2);
    sun_dist = (longint'($urandom_range(20000, 26000)) << 30);
    for (int i = 0; i < 3; i++) begin
      u[i] = (i == ax) ? 48'(sun_dist) : 48'(longint'($urandom_range(0, 4000)) << 30);
      if ($urandom_range(0, 1)) u[i] = -u[i];
    end
    along = longint'($urandom_range(0, 1 << 14)) << 18;
    perp_lim = (radius_reg > 64'd0 && radius_reg < (64'd1 << 40)) ? radius_reg * 2 : 64'd1 << 31;
    for (int i = 0; i < 3; i++) begin
      if (i == ax) begin
        // Mostly on the far side of the Earth from the sun.
        s[i] = $urandom_range(0, 3) != 0 ? 48'(-along) : 48'(along);
        if (u[i] < 0) s[i] = -s[i];
      end else begin
        s[i] = 48'({$urandom, $urandom} % perp_lim);
        if ($urandom_range(0, 1)) s[i] = -s[i];
      end
    end
  endtask

  task automatic random_words(input int count);
    logic signed [47:0] s [3];
    logic signed [47:0] u [3];
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          for (int i = 0; i < 3; i++) begin
            s[i] = any48();
            u[i] = any48();
          end
        end
        2, 3: begin
          for (int i = 0; i < 3; i++) begin
            s[i] = spread48();
            u[i] = spread48();
          end
        end
        default: random_geometry(s, u);
      endcase
      send_word(s, u);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Field extremes, zero vectors, a satellite deep in the shadow and one just
  // clear of it, and reflectivity exactly one (the reset value).
  task automatic test_directed;
    logic signed [47:0] s [3];
    logic signed [47:0] u [3];
    localparam logic signed [47:0] MAXV = 48'h7FFF_FFFF_FFFF;
    localparam logic signed [47:0] MINV = 48'h8000_0000_0000;
    localparam logic signed [47:0] ONE  = 48'sd1 <<< 30;
    s = '{MAXV, MAXV, MAXV}; u = '{MINV, MINV, MINV}; send_word(s, u);
    s = '{MINV, MINV, MINV}; u = '{MAXV, MAXV, MAXV}; send_word(s, u);
    s = '{MINV, MAXV, 48'sd0}; u = '{MINV, MINV, MAXV}; send_word(s, u);
    s = '{MAXV, 48'sd1, -48'sd1}; u = '{48'sd0, 48'sd0, 48'sd0}; send_word(s, u);
    // Sun at the origin: never in shadow.
    s = '{-ONE * 2, 48'sd0, 48'sd0}; u = '{48'sd0, 48'sd0, 48'sd0}; send_word(s, u);
    // Satellite at the Earth's centre.
    s = '{48'sd0, 48'sd0, 48'sd0}; u = '{ONE * 23000, 48'sd0, 48'sd0}; send_word(s, u);
    s = '{48'sd0, 48'sd0, 48'sd0}; u = '{48'sd0, 48'sd0, 48'sd0}; send_word(s, u);
    // Directly behind the Earth, and beside it just outside the cylinder.
    s = '{-ONE * 3, ONE / 2, 48'sd0}; u = '{ONE * 23000, 48'sd0, 48'sd0}; send_word(s, u);
    s = '{-ONE * 3, ONE + ONE / 8, 48'sd0}; u = '{ONE * 23000, 48'sd0, 48'sd0}; send_word(s, u);
    // Sunward side of the Earth at the same offset: lit.
    s = '{ONE * 3, ONE / 2, 48'sd0}; u = '{ONE * 23000, 48'sd0, 48'sd0}; send_word(s, u);
    s = '{48'sd1, 48'sd1, 48'sd1}; u = '{-48'sd1, 48'sd0, 48'sd0}; send_word(s, u);
    s = '{48'sd0, 48'sd0, -48'sd1}; u = '{48'sd0, 48'sd0, 48'sd1}; send_word(s, u);
    s = '{ONE, -ONE, ONE}; u = '{-ONE * 16000, ONE * 16000, -ONE * 9000}; send_word(s, u);
    drain();
  endtask

  // Random words under one register setting.
  task automatic test_setting(input longint unsigned refl, input longint unsigned atm,
                              input longint unsigned radius, input int count);
    set_regs(refl, atm, radius);
    random_words(count);
    drain();
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: each strobe is compared with the oldest expectation.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    accel_t e;
    if (!rst && done) begin
      results_seen++;
      if (in_shadow) shadow_seen++;
      if (accel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result word at cycle %0d", cycles);
      end else begin
        e = accel_q.pop_front();
        if (accel_x !== e.ax || accel_y !== e.ay || accel_z !== e.az ||
            in_shadow !== e.shadow) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at cycle %0d: expected %h %h %h %b, got %h %h %h %b",
                     cycles, e.ax, e.ay, e.az, e.shadow,
                     accel_x, accel_y, accel_z, in_shadow);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Run timed out after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    cycles       = 0;
    mismatches   = 0;
    results_seen = 0;
    shadow_seen  = 0;
    words_sent   = 0;
    burst_left   = 0;
    refl_reg     = 64'(REFL_RESET);
    atm_reg      = 64'(ATM_RESET);
    radius_reg   = 64'(RAD_RESET);
    rst       = 1'b1;
    start     = 1'b0;
    sat_x     = '0;
    sat_y     = '0;
    sat_z     = '0;
    sun_x     = '0;
    sun_y     = '0;
    sun_z     = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_REFLECTIVITY;
    cfg_data  = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values first, then a sweep through the extremes of every register.
    test_directed();
    test_setting(64'd16384, 64'd2684355, 64'd1 << 30, 200);
    test_setting(64'd0, 64'hFFFF_FFFF, 64'd0, 150);
    test_setting(64'd65535, 64'hFFFF_FFFF, 64'h7FFF_FFFF_FFFF, 150);
    test_setting(64'd16385, 64'd0, 64'd1 << 29, 150);
    test_setting(64'd21300, 64'd2684355, 64'd1 << 31, 200);
    test_setting(64'($urandom_range(0, 65535)), 64'($urandom), 64'd1 << $urandom_range(20, 40),
                 150);
    test_setting(64'd16383, 64'd1, 64'h0000_4000_0000 + 64'd12345, 150);

    drain();
    repeat (SETTLE) @(posedge clk);
    $display("Sent %0d words over eight register settings; %0d results checked, %0d shadowed.",
             words_sent, results_seen, shadow_seen);
    $display("%0d mismatches, %0d results still outstanding.", mismatches, accel_q.size());
    if (mismatches == 0 && accel_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: solar_pressure_accel.f
+incdir+sv
sv/spa_pkg.sv
sv/spa_queue.sv
sv/spa_unit.sv
sv/spa_front.sv
sv/spa_back.sv
sv/solar_pressure_accel.sv
tb/solar_pressure_accel_tb.sv
